>>> rtl/core/rgbf_pkg.sv
// rgbf_pkg: shared types, register codes and per-channel step functions
// for the RGB fade engine. No dependencies.
package rgbf_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int COLOR_W    = CHAN_W * NUM_CHAN;
    localparam int STEP_W     = 9;
    localparam int LAPSE_W    = 14;
    localparam int REPEAT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COLOR_W;

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELATIVE_MODE  = 3'd0,
        REG_START_COLOR    = 3'd1,
        REG_TARGET_COLOR   = 3'd2,
        REG_REL_STEP_RED   = 3'd3,
        REG_REL_STEP_GREEN = 3'd4,
        REG_REL_STEP_BLUE  = 3'd5,
        REG_LAPSE_TICKS    = 3'd6,
        REG_REPEAT_COUNT   = 3'd7
    } t_reg_idx;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_rgb;
    typedef logic [NUM_CHAN-1:0][STEP_W-1:0] t_rgb_step;

    typedef struct packed {
        logic                relative_mode;
        t_rgb                start_color;
        t_rgb                target_color;
        t_rgb_step           rel_step;
        logic [LAPSE_W-1:0]  lapse_ticks;
        logic [REPEAT_W-1:0] repeat_count;
    } t_cfg;

    typedef struct packed {
        logic load_start;
        logic load_lapse;
        logic load_repeat;
    } t_cfg_wr;

    typedef struct packed {
        t_rgb color;
        logic updated;
        logic done_res;
    } t_result;

    function automatic logic [CHAN_W-1:0] abs_step(
        input logic [CHAN_W-1:0] from,
        input logic [CHAN_W-1:0] to,
        input logic [CHAN_W-1:0] cur
    );
        logic [CHAN_W-1:0] v;
        if (to > from) begin
            v = (cur >= to) ? to : cur + CHAN_W'(1);
        end else if (to < from) begin
            v = (cur <= to) ? to : cur - CHAN_W'(1);
        end else begin
            v = cur;
        end
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] rel_step(
        input logic [CHAN_W-1:0] cur,
        input logic [STEP_W-1:0] step
    );
        logic signed [CHAN_W+1:0] v;
        v = $signed({2'b00, cur}) + $signed({step[STEP_W-1], step});
        return v[CHAN_W+1] ? '0 : v[CHAN_W-1:0];
    endfunction

endpackage

>>> rtl/core/rgbf_cfg_regs.sv
// rgbf_cfg_regs: configuration register file with reload strobes.
// Depends on rgbf_pkg.
module rgbf_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [rgbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgbf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rgbf_pkg::t_cfg                   o_cfg,
    output rgbf_pkg::t_cfg_wr                o_cfg_wr
);

    rgbf_pkg::t_cfg   r_cfg;
    rgbf_pkg::t_cfg   n_cfg;
    rgbf_pkg::t_cfg_wr n_wr;

    always_comb begin
        n_cfg = r_cfg;
        n_wr  = '0;
        if (i_cfg_valid) begin
            case (rgbf_pkg::t_reg_idx'(i_cfg_index))
                rgbf_pkg::REG_RELATIVE_MODE: begin
                    n_cfg.relative_mode = i_cfg_data[0];
                end
                rgbf_pkg::REG_START_COLOR: begin
                    n_cfg.start_color = i_cfg_data[rgbf_pkg::COLOR_W-1:0];
                    n_wr.load_start   = 1'b1;
                end
                rgbf_pkg::REG_TARGET_COLOR: begin
                    n_cfg.target_color = i_cfg_data[rgbf_pkg::COLOR_W-1:0];
                end
                rgbf_pkg::REG_REL_STEP_RED: begin
                    n_cfg.rel_step[rgbf_pkg::CH_RED] = i_cfg_data[rgbf_pkg::STEP_W-1:0];
                end
                rgbf_pkg::REG_REL_STEP_GREEN: begin
                    n_cfg.rel_step[rgbf_pkg::CH_GREEN] = i_cfg_data[rgbf_pkg::STEP_W-1:0];
                end
                rgbf_pkg::REG_REL_STEP_BLUE: begin
                    n_cfg.rel_step[rgbf_pkg::CH_BLUE] = i_cfg_data[rgbf_pkg::STEP_W-1:0];
                end
                rgbf_pkg::REG_LAPSE_TICKS: begin
                    n_cfg.lapse_ticks = i_cfg_data[rgbf_pkg::LAPSE_W-1:0];
                    n_wr.load_lapse   = 1'b1;
                end
                rgbf_pkg::REG_REPEAT_COUNT: begin
                    n_cfg.repeat_count = i_cfg_data[rgbf_pkg::REPEAT_W-1:0];
                    n_wr.load_repeat   = 1'b1;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg    = n_wr.load_start ? r_cfg : r_cfg;
    assign o_cfg_wr = n_wr;

endmodule

>>> rtl/core/rgbf_engine.sv
// rgbf_engine: fade state (shown and working colour, prescaler, repeats)
// and the single-pass tick update. Depends on rgbf_pkg.
module rgbf_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbf_pkg::t_cfg      i_cfg,
    input  rgbf_pkg::t_cfg_wr   i_cfg_wr,
    input  logic [rgbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                i_push,
    input  logic                i_tick,
    output rgbf_pkg::t_result   o_result
);

    rgbf_pkg::t_rgb                r_shown;
    rgbf_pkg::t_rgb                r_working;
    logic [rgbf_pkg::LAPSE_W-1:0]  r_lapse;
    logic [rgbf_pkg::REPEAT_W-1:0] r_repeats;
    logic                          r_pass_done;

    rgbf_pkg::t_rgb                n_shown;
    rgbf_pkg::t_rgb                n_working;
    logic [rgbf_pkg::LAPSE_W-1:0]  n_lapse;
    logic [rgbf_pkg::REPEAT_W-1:0] n_repeats;
    logic                          n_pass_done;

    rgbf_pkg::t_rgb abs_next;
    rgbf_pkg::t_rgb rel_next;
    logic           arrived;
    logic           upd;

    always_comb begin
        for (int ch = 0; ch < rgbf_pkg::NUM_CHAN; ch++) begin
            abs_next[ch] = rgbf_pkg::abs_step(i_cfg.start_color[ch],
                                              i_cfg.target_color[ch], r_working[ch]);
            rel_next[ch] = rgbf_pkg::rel_step(r_shown[ch], i_cfg.rel_step[ch]);
        end
    end

    assign arrived = (abs_next == i_cfg.target_color);
    assign upd     = i_tick && (r_repeats != '0) && (r_lapse == '0);

    always_comb begin
        n_shown     = r_shown;
        n_working   = r_working;
        n_lapse     = r_lapse;
        n_repeats   = r_repeats;
        n_pass_done = r_pass_done;
        if (i_push && i_tick && (r_repeats != '0)) begin
            if (r_lapse == '0) begin
                n_lapse = i_cfg.lapse_ticks;
                if (r_pass_done) begin
                    n_repeats   = r_repeats - rgbf_pkg::REPEAT_W'(1);
                    n_pass_done = 1'b0;
                end
                if (i_cfg.relative_mode) begin
                    n_shown     = rel_next;
                    n_pass_done = 1'b1;
                end else begin
                    n_shown = abs_next;
                    if (arrived) begin
                        n_working   = i_cfg.start_color;
                        n_pass_done = 1'b1;
                    end else begin
                        n_working = abs_next;
                    end
                end
            end else begin
                n_lapse = r_lapse - rgbf_pkg::LAPSE_W'(1);
            end
        end
        if (i_cfg_wr.load_start) begin
            n_working = i_cfg_data[rgbf_pkg::COLOR_W-1:0];
        end
        if (i_cfg_wr.load_lapse) begin
            n_lapse = i_cfg_data[rgbf_pkg::LAPSE_W-1:0];
        end
        if (i_cfg_wr.load_repeat) begin
            n_repeats   = i_cfg_data[rgbf_pkg::REPEAT_W-1:0];
            n_pass_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown     <= '0;
            r_working   <= '0;
            r_lapse     <= '0;
            r_repeats   <= '0;
            r_pass_done <= 1'b0;
        end else begin
            r_shown     <= n_shown;
            r_working   <= n_working;
            r_lapse     <= n_lapse;
            r_repeats   <= n_repeats;
            r_pass_done <= n_pass_done;
        end
    end

    assign o_result.color    = n_shown;
    assign o_result.updated  = upd;
    assign o_result.done_res = (n_repeats == '0);

    a_lapse_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && upd && !i_cfg_wr.load_lapse) |=> (r_lapse == $past(i_cfg.lapse_ticks)))
        else $error("lapse counter not reloaded after update");

    a_repeats_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_wr.load_repeat |=> (r_repeats <= $past(r_repeats)))
        else $error("repeat counter grew without a load");

    a_no_update_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_repeats == '0) |-> !upd)
        else $error("update while repeats exhausted");

endmodule

>>> rtl/core/rgbf_out_buf.sv
// rgbf_out_buf: two-entry output register with skid stage.
// Depends on rgbf_pkg.
module rgbf_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rgbf_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output rgbf_pkg::t_result o_data
);

    rgbf_pkg::t_result r_main;
    rgbf_pkg::t_result r_skid;
    logic              r_main_v;
    logic              r_skid_v;
    logic              pop;

    assign pop = r_main_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_v) begin
                    r_main   <= r_skid;
                    r_skid_v <= 1'b0;
                end else begin
                    r_main   <= i_data;
                    r_main_v <= i_push;
                end
            end else if (!r_main_v) begin
                r_main   <= i_data;
                r_main_v <= i_push;
            end else if (i_push) begin
                r_skid   <= i_data;
                r_skid_v <= 1'b1;
            end
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry without main entry");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_v && i_stall) |=> r_skid_v)
        else $error("transfer lost while output stalled");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (r_main == $past(r_skid)))
        else $error("skid entry not advanced to output");

endmodule

>>> rtl/core/rgb_fade_engine_core.sv
// RGB fade engine, top level. One tick transfer is taken per clock: the
// fade state updates at the edge the tick is accepted and the result
// (shown colour, updated, done) is registered in the output register, or in
// the one-entry skid stage behind it while the output is stalled, so a tick
// is taken every cycle as long as the output side keeps pace; input stall
// rises only when both output entries hold results.
// Configuration writes are always accepted (ready always high).
// Depends on rgbf_pkg, rgbf_cfg_regs, rgbf_engine, rgbf_out_buf.
module rgb_fade_engine_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tick_valid,
    output logic                             o_tick_stall,
    input  logic                             i_tick,
    output logic                             o_res_valid,
    input  logic                             i_res_stall,
    output logic [rgbf_pkg::CHAN_W-1:0]      o_red,
    output logic [rgbf_pkg::CHAN_W-1:0]      o_green,
    output logic [rgbf_pkg::CHAN_W-1:0]      o_blue,
    output logic                             o_updated,
    output logic                             o_done_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rgbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgbf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    rgbf_pkg::t_cfg    cfg;
    rgbf_pkg::t_cfg_wr cfg_wr;
    rgbf_pkg::t_result eng_res;
    rgbf_pkg::t_result out_res;
    logic              buf_full;
    logic              push;

    assign o_cfg_ready  = 1'b1;
    assign o_tick_stall = buf_full;
    assign push         = i_tick_valid && !buf_full;

    rgbf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cfg_wr    (cfg_wr)
    );

    rgbf_engine u_eng (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_tick     (i_tick),
        .o_result   (eng_res)
    );

    rgbf_out_buf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (eng_res),
        .o_full  (buf_full),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_data  (out_res)
    );

    assign o_red      = out_res.color[rgbf_pkg::CH_RED];
    assign o_green    = out_res.color[rgbf_pkg::CH_GREEN];
    assign o_blue     = out_res.color[rgbf_pkg::CH_BLUE];
    assign o_updated  = out_res.updated;
    assign o_done_res = out_res.done_res;

endmodule
